// ----- rtl/thp_pkg.sv -----
package thp_pkg;

    localparam int PERIOD_BITS = 8;
    localparam int DZ_BITS     = 7;
    localparam int BTN_BITS    = 13;
    localparam int STICK_BITS  = 8;
    localparam int HAT_BITS    = 4;
    localparam int LEVEL_BITS  = 2;
    localparam int CFG_IDX_BITS = 2;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_PERIOD_SLOW = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_PERIOD_MID  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_PERIOD_FAST = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_DEADZONE    = 2'd3;

    // register reset values
    localparam logic [PERIOD_BITS-1:0] RST_PERIOD_SLOW = 8'd50;
    localparam logic [PERIOD_BITS-1:0] RST_PERIOD_MID  = 8'd33;
    localparam logic [PERIOD_BITS-1:0] RST_PERIOD_FAST = 8'd25;
    localparam logic [DZ_BITS-1:0]     RST_DEADZONE    = 7'd64;

    localparam logic [STICK_BITS-1:0] STICK_CENTER = 8'd128;

    // speed levels
    localparam logic [LEVEL_BITS-1:0] LVL_SLOW = 2'd0;
    localparam logic [LEVEL_BITS-1:0] LVL_MID  = 2'd1;
    localparam logic [LEVEL_BITS-1:0] LVL_FAST = 2'd2;

    // pad button bit positions
    localparam int BTN_SOUTH  = 0;
    localparam int BTN_EAST   = 1;
    localparam int BTN_WEST   = 2;
    localparam int BTN_NORTH  = 3;
    localparam int BTN_L1     = 4;
    localparam int BTN_R1     = 5;
    localparam int BTN_SELECT = 6;
    localparam int BTN_START  = 7;
    localparam int BTN_HOME   = 8;
    localparam int BTN_UP     = 9;
    localparam int BTN_DOWN   = 10;
    localparam int BTN_LEFT   = 11;
    localparam int BTN_RIGHT  = 12;

    // hat codes
    localparam logic [HAT_BITS-1:0] HAT_UP        = 4'd0;
    localparam logic [HAT_BITS-1:0] HAT_UPRIGHT   = 4'd1;
    localparam logic [HAT_BITS-1:0] HAT_RIGHT     = 4'd2;
    localparam logic [HAT_BITS-1:0] HAT_DOWNRIGHT = 4'd3;
    localparam logic [HAT_BITS-1:0] HAT_DOWN      = 4'd4;
    localparam logic [HAT_BITS-1:0] HAT_DOWNLEFT  = 4'd5;
    localparam logic [HAT_BITS-1:0] HAT_LEFT      = 4'd6;
    localparam logic [HAT_BITS-1:0] HAT_UPLEFT    = 4'd7;
    localparam logic [HAT_BITS-1:0] HAT_NONE      = 4'd8;

    typedef struct packed {
        logic                button_two;
        logic                button_one;
        logic                select_out;
        logic                run_out;
        logic [HAT_BITS-1:0] hat;
    } report_t;

endpackage

// ----- rtl/thp_div.sv -----
// Restoring divider, one quotient bit per cycle. Only the quotient LSB is
// kept: the turbo phase is the parity of elapsed / period.
module thp_div #(
    parameter int W = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [W-1:0]                      dividend,
    input  logic [thp_pkg::PERIOD_BITS-1:0]   divisor,
    output logic                              done,
    output logic                              q_lsb
);
    import thp_pkg::*;

    localparam int CNT_BITS = $clog2(W);

    logic                    busy_reg;
    logic [CNT_BITS-1:0]     cnt_reg;
    logic [W-1:0]            shift_reg;
    logic [PERIOD_BITS-1:0]  rem_reg;
    logic [PERIOD_BITS-1:0]  dvs_reg;
    logic                    done_reg;
    logic                    q_reg;

    logic [PERIOD_BITS:0]    trial;
    logic                    ge;
    logic [PERIOD_BITS:0]    diff;

    assign trial = {rem_reg, shift_reg[W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            shift_reg <= dividend;
            rem_reg   <= '0;
            dvs_reg   <= divisor;
        end else if (busy_reg) begin
            shift_reg <= {shift_reg[W-2:0], 1'b0};
            rem_reg   <= ge ? diff[PERIOD_BITS-1:0] : trial[PERIOD_BITS-1:0];
            q_reg     <= ge;
        end
    end

    assign done  = done_reg;
    assign q_lsb = q_reg;

endmodule

// ----- rtl/thp_map.sv -----
// Report builder: direct buttons, turbo merge, stick deadzone and hat priority.
module thp_map (
    input  logic [thp_pkg::BTN_BITS-1:0]   buttons,
    input  logic [thp_pkg::STICK_BITS-1:0] stick_x,
    input  logic [thp_pkg::STICK_BITS-1:0] stick_y,
    input  logic [thp_pkg::DZ_BITS-1:0]    deadzone,
    input  logic                           turbo_two,
    input  logic                           turbo_one,
    output thp_pkg::report_t               report
);
    import thp_pkg::*;

    logic [STICK_BITS:0] x_ext, y_ext, x_plus, y_plus, hi;
    logic up, down, left, right;

    // x < 128 - dz  <=>  x + dz < 128, no negative values needed
    assign x_ext  = {1'b0, stick_x};
    assign y_ext  = {1'b0, stick_y};
    assign x_plus = x_ext + {2'b00, deadzone};
    assign y_plus = y_ext + {2'b00, deadzone};
    assign hi     = {1'b0, STICK_CENTER} + {2'b00, deadzone};

    assign up    = buttons[BTN_UP]    || (y_plus < {1'b0, STICK_CENTER});
    assign down  = buttons[BTN_DOWN]  || (y_ext > hi);
    assign left  = buttons[BTN_LEFT]  || (x_plus < {1'b0, STICK_CENTER});
    assign right = buttons[BTN_RIGHT] || (x_ext > hi);

    always_comb begin
        report.button_two = buttons[BTN_SOUTH] | turbo_two;
        report.button_one = buttons[BTN_EAST]  | turbo_one;
        report.select_out = buttons[BTN_SELECT] | buttons[BTN_HOME];
        report.run_out    = buttons[BTN_START]  | buttons[BTN_HOME];
        // diagonals first, then single directions
        if (up && right)        report.hat = HAT_UPRIGHT;
        else if (up && left)    report.hat = HAT_UPLEFT;
        else if (down && right) report.hat = HAT_DOWNRIGHT;
        else if (down && left)  report.hat = HAT_DOWNLEFT;
        else if (up)            report.hat = HAT_UP;
        else if (down)          report.hat = HAT_DOWN;
        else if (left)          report.hat = HAT_LEFT;
        else if (right)         report.hat = HAT_RIGHT;
        else                    report.hat = HAT_NONE;
    end

endmodule

// ----- rtl/gamepad_turbo_hat_mapper.sv -----
// Turbo pad mapper: pad updates and millisecond ticks in, console reports out.
//
// Input channel (s_valid/s_ready): s_mode 0 is a pad update carrying
// s_pad_buttons, s_stick_x and s_stick_y; s_mode 1 is a one-millisecond tick
// whose payload fields are ignored. Every update yields one report. A tick
// yields one report only while west or north (turbo) is held, else nothing.
// Result channel (m_valid/m_ready): button II, button I, select, run, hat.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (0 slow,
// 1 mid, 2 fast half-period in ms, 3 stick deadzone); write only while idle.
//
// Flow: one item at a time. A report costs two passes of a shared
// one-bit-per-cycle divider (elapsed / half-period for west, then north),
// then the report is loaded into the output slot and m_valid rises. The
// next item can be accepted once the sequencer is back in idle.
// A tick with no turbo held is consumed straight from idle and s_ready stays high.
// Reset (aresetn low, synchronous) restores register defaults, clears the
// stored pad, sets speed level mid and drops any pending report.
// If the receiver stalls, the finished report waits in the output register;
// the next item may be accepted, but its report waits until the slot frees.
module gamepad_turbo_hat_mapper #(
    parameter int ELAPSED_BITS = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration
    input  logic                                 cfg_we,
    input  logic [thp_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [thp_pkg::PERIOD_BITS-1:0]      cfg_wdata,
    // input items
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_mode,
    input  logic [thp_pkg::BTN_BITS-1:0]         s_pad_buttons,
    input  logic [thp_pkg::STICK_BITS-1:0]       s_stick_x,
    input  logic [thp_pkg::STICK_BITS-1:0]       s_stick_y,
    // result items
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_button_two,
    output logic                                 m_button_one,
    output logic                                 m_select_out,
    output logic                                 m_run_out,
    output logic [thp_pkg::HAT_BITS-1:0]         m_hat
);
    import thp_pkg::*;

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_WSTART = 3'd1;
    localparam logic [2:0] ST_WWAIT  = 3'd2;
    localparam logic [2:0] ST_NSTART = 3'd3;
    localparam logic [2:0] ST_NWAIT  = 3'd4;
    localparam logic [2:0] ST_PEND   = 3'd5;

    logic [2:0]              state_reg;

    // config registers
    logic [PERIOD_BITS-1:0]  per_slow_reg, per_mid_reg, per_fast_reg;
    logic [DZ_BITS-1:0]      dz_reg;

    // pad state
    logic [BTN_BITS-1:0]     btn_reg;
    logic [STICK_BITS-1:0]   x_reg, y_reg;
    logic [LEVEL_BITS-1:0]   level_reg;
    logic                    l1_prev_reg, r1_prev_reg;
    logic                    west_held_reg, north_held_reg;
    logic [ELAPSED_BITS-1:0] west_ms_reg, north_ms_reg;

    // per-item working state
    logic [PERIOD_BITS-1:0]  period_reg;
    logic                    west_odd_reg, north_odd_reg;

    // output slot
    logic                    out_valid_reg;
    report_t                 out_reg;

    logic                    accept, out_free;
    logic                    l1, r1, west_b, north_b;
    logic [LEVEL_BITS-1:0]   level_dn, level_next;
    logic [PERIOD_BITS-1:0]  period_sel;
    logic                    div_start, div_done, div_q;
    logic [ELAPSED_BITS-1:0] div_dividend;
    report_t                 report;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;

    assign l1      = s_pad_buttons[BTN_L1];
    assign r1      = s_pad_buttons[BTN_R1];
    assign west_b  = s_pad_buttons[BTN_WEST];
    assign north_b = s_pad_buttons[BTN_NORTH];

    // L1 edge lowers first, then R1 edge raises; both clamp to slow..fast
    assign level_dn   = (l1 && !l1_prev_reg && level_reg != LVL_SLOW) ?
                        level_reg - 1'b1 : level_reg;
    assign level_next = (r1 && !r1_prev_reg && level_dn < LVL_FAST) ?
                        level_dn + 1'b1 : level_dn;

    // half-period from the level before this item; zero acts as one
    always_comb begin
        case (level_reg)
            LVL_SLOW: period_sel = per_slow_reg;
            LVL_MID:  period_sel = per_mid_reg;
            default:  period_sel = per_fast_reg;
        endcase
        if (period_sel == '0) period_sel = PERIOD_BITS'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            per_slow_reg <= RST_PERIOD_SLOW;
            per_mid_reg  <= RST_PERIOD_MID;
            per_fast_reg <= RST_PERIOD_FAST;
            dz_reg       <= RST_DEADZONE;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_PERIOD_SLOW: per_slow_reg <= cfg_wdata;
                REG_PERIOD_MID:  per_mid_reg  <= cfg_wdata;
                REG_PERIOD_FAST: per_fast_reg <= cfg_wdata;
                REG_DEADZONE:    dz_reg       <= cfg_wdata[DZ_BITS-1:0];
                default:         ;
            endcase
        end
    end

    // sequencer and pad state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            btn_reg        <= '0;
            x_reg          <= STICK_CENTER;
            y_reg          <= STICK_CENTER;
            level_reg      <= LVL_MID;
            l1_prev_reg    <= 1'b0;
            r1_prev_reg    <= 1'b0;
            west_held_reg  <= 1'b0;
            north_held_reg <= 1'b0;
            west_ms_reg    <= '0;
            north_ms_reg   <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (accept && !s_mode) begin
                        btn_reg     <= s_pad_buttons;
                        x_reg       <= s_stick_x;
                        y_reg       <= s_stick_y;
                        level_reg   <= level_next;
                        l1_prev_reg <= l1;
                        r1_prev_reg <= r1;
                        period_reg  <= period_sel;
                        // new press restarts its count
                        if (west_b && !west_held_reg) west_ms_reg <= '0;
                        if (north_b && !north_held_reg) north_ms_reg <= '0;
                        west_held_reg  <= west_b;
                        north_held_reg <= north_b;
                        state_reg      <= ST_WSTART;
                    end else if (accept && (west_held_reg || north_held_reg)) begin
                        // tick: stored pad already settled the shoulder edges
                        if (west_held_reg)  west_ms_reg  <= west_ms_reg + 1'b1;
                        if (north_held_reg) north_ms_reg <= north_ms_reg + 1'b1;
                        period_reg <= period_sel;
                        state_reg  <= ST_WSTART;
                    end
                end
                ST_WSTART: state_reg <= ST_WWAIT;
                ST_WWAIT: begin
                    if (div_done) begin
                        west_odd_reg <= div_q;
                        state_reg    <= ST_NSTART;
                    end
                end
                ST_NSTART: state_reg <= ST_NWAIT;
                ST_NWAIT: begin
                    if (div_done) begin
                        north_odd_reg <= div_q;
                        state_reg     <= ST_PEND;
                    end
                end
                ST_PEND: begin
                    if (out_free) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign div_start    = (state_reg == ST_WSTART) || (state_reg == ST_NSTART);
    assign div_dividend = (state_reg == ST_WSTART) ? west_ms_reg : north_ms_reg;

    thp_div #(
        .W (ELAPSED_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (period_reg),
        .done     (div_done),
        .q_lsb    (div_q)
    );

    // turbo is on during even half-periods
    thp_map u_map (
        .buttons   (btn_reg),
        .stick_x   (x_reg),
        .stick_y   (y_reg),
        .deadzone  (dz_reg),
        .turbo_two (west_held_reg && !west_odd_reg),
        .turbo_one (north_held_reg && !north_odd_reg),
        .report    (report)
    );

    // output slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (state_reg == ST_PEND && out_free) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_PEND && out_free) out_reg <= report;
    end

    assign m_valid      = out_valid_reg;
    assign m_button_two = out_reg.button_two;
    assign m_button_one = out_reg.button_one;
    assign m_select_out = out_reg.select_out;
    assign m_run_out    = out_reg.run_out;
    assign m_hat        = out_reg.hat;

endmodule

// ----- rtl/thp_checker.sv -----
module thp_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic                            s_mode,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic                            m_button_two,
    input  logic                            m_button_one,
    input  logic                            m_select_out,
    input  logic                            m_run_out,
    input  logic [thp_pkg::HAT_BITS-1:0]    m_hat
);
    import thp_pkg::*;

    // stalled report holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hat) && $stable(m_button_two)
            && $stable(m_button_one) && $stable(m_select_out) && $stable(m_run_out))
        else $error("report changed while stalled");

    // hat stays within the nine codes
    a_hat_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_hat <= HAT_NONE)
        else $error("hat code out of range");

    // reset drops a pending report
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("report valid after reset");

    // a pad update always starts a report, so the block goes busy
    a_update_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_mode |=> !s_ready)
        else $error("still ready after pad update");

endmodule

bind gamepad_turbo_hat_mapper thp_checker u_thp_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_mode       (s_mode),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_button_two (m_button_two),
    .m_button_one (m_button_one),
    .m_select_out (m_select_out),
    .m_run_out    (m_run_out),
    .m_hat        (m_hat)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

    import thp_pkg::*;

    // ------------------------------------------------------------------
    // Run constants
    // ------------------------------------------------------------------
    localparam int ELAPSED_W        = 32;
    localparam int HALF_PERIOD_NS   = 6;
    localparam int RESET_CYCLES     = 7;
    // long enough for an in-flight report to reach m_valid, with margin on top
    localparam int DRAIN_CYCLES     = 2 * ELAPSED_W + 40;
    localparam int LONG_HOLD_CYCLES = 600;
    localparam int CYCLE_LIMIT      = 1_500_000;

    // item kinds on the input channel
    localparam logic MODE_UPDATE = 1'b0;
    localparam logic MODE_TICK   = 1'b1;

    // ------------------------------------------------------------------
    // Scoreboard: own copy of the mapper state, one expected report per
    // pad update and per tick that lands while a turbo button is held.
    // ------------------------------------------------------------------
    class turbo_report_scoreboard;
        logic [PERIOD_BITS-1:0] period_slow;
        logic [PERIOD_BITS-1:0] period_mid;
        logic [PERIOD_BITS-1:0] period_fast;
        logic [DZ_BITS-1:0]     deadzone;

        logic [BTN_BITS-1:0]    pad_btn;
        logic [STICK_BITS-1:0]  pad_x;
        logic [STICK_BITS-1:0]  pad_y;
        logic [LEVEL_BITS-1:0]  speed;
        bit                     l1_prev;
        bit                     r1_prev;
        bit                     west_held;
        bit                     north_held;
        logic [ELAPSED_W-1:0]   west_ms;
        logic [ELAPSED_W-1:0]   north_ms;

        report_t expected_reports[$];
        int      errors;
        int      checked;
        int      updates;
        int      ticks;
        int      turbo_ticks;

        function new();
            period_slow = RST_PERIOD_SLOW;
            period_mid  = RST_PERIOD_MID;
            period_fast = RST_PERIOD_FAST;
            deadzone    = RST_DEADZONE;
            pad_btn     = '0;
            pad_x       = STICK_CENTER;
            pad_y       = STICK_CENTER;
            speed       = LVL_MID;
            l1_prev     = 1'b0;
            r1_prev     = 1'b0;
            west_held   = 1'b0;
            north_held  = 1'b0;
            west_ms     = '0;
            north_ms    = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [PERIOD_BITS-1:0] data);
            case (idx)
                REG_PERIOD_SLOW: period_slow = data;
                REG_PERIOD_MID:  period_mid  = data;
                REG_PERIOD_FAST: period_fast = data;
                REG_DEADZONE:    deadzone    = data[DZ_BITS-1:0];
                default: ;
            endcase
        endfunction

        function report_t build_expected_report();
            report_t              r;
            logic [ELAPSED_W-1:0] period;
            logic [ELAPSED_W-1:0] phase;
            int                   lo;
            int                   hi;
            bit                   up;
            bit                   down;
            bit                   left;
            bit                   right;

            // half-period comes from the level before this update's shoulders
            case (speed)
                LVL_SLOW: period = ELAPSED_W'(period_slow);
                LVL_MID:  period = ELAPSED_W'(period_mid);
                default:  period = ELAPSED_W'(period_fast);
            endcase
            if (period == 0)
                period = 1;

            if (pad_btn[BTN_L1] && !l1_prev && speed > LVL_SLOW)
                speed = speed - 1'b1;
            if (pad_btn[BTN_R1] && !r1_prev && speed < LVL_FAST)
                speed = speed + 1'b1;
            l1_prev = pad_btn[BTN_L1];
            r1_prev = pad_btn[BTN_R1];

            r = '0;
            if (pad_btn[BTN_WEST]) begin
                if (!west_held) begin
                    west_ms   = '0;
                    west_held = 1'b1;
                end
                phase = west_ms / period;
                if (!phase[0])
                    r.button_two = 1'b1;
            end else begin
                west_held = 1'b0;
            end
            if (pad_btn[BTN_NORTH]) begin
                if (!north_held) begin
                    north_ms   = '0;
                    north_held = 1'b1;
                end
                phase = north_ms / period;
                if (!phase[0])
                    r.button_one = 1'b1;
            end else begin
                north_held = 1'b0;
            end

            if (pad_btn[BTN_SOUTH])
                r.button_two = 1'b1;
            if (pad_btn[BTN_EAST])
                r.button_one = 1'b1;
            r.select_out = pad_btn[BTN_SELECT] || pad_btn[BTN_HOME];
            r.run_out    = pad_btn[BTN_START] || pad_btn[BTN_HOME];

            lo    = int'(STICK_CENTER) - int'(deadzone);
            hi    = int'(STICK_CENTER) + int'(deadzone);
            up    = pad_btn[BTN_UP]    || (int'(pad_y) < lo);
            down  = pad_btn[BTN_DOWN]  || (int'(pad_y) > hi);
            left  = pad_btn[BTN_LEFT]  || (int'(pad_x) < lo);
            right = pad_btn[BTN_RIGHT] || (int'(pad_x) > hi);

            if (up && right)        r.hat = HAT_UPRIGHT;
            else if (up && left)    r.hat = HAT_UPLEFT;
            else if (down && right) r.hat = HAT_DOWNRIGHT;
            else if (down && left)  r.hat = HAT_DOWNLEFT;
            else if (up)            r.hat = HAT_UP;
            else if (down)          r.hat = HAT_DOWN;
            else if (left)          r.hat = HAT_LEFT;
            else if (right)         r.hat = HAT_RIGHT;
            else                    r.hat = HAT_NONE;
            return r;
        endfunction

        // returns 1 when the item produces a report
        function bit note_item(logic mode, logic [BTN_BITS-1:0] btn,
                               logic [STICK_BITS-1:0] x, logic [STICK_BITS-1:0] y);
            if (mode == MODE_UPDATE) begin
                updates++;
                pad_btn = btn;
                pad_x   = x;
                pad_y   = y;
                expected_reports.push_back(build_expected_report());
                return 1'b1;
            end
            ticks++;
            if (!west_held && !north_held)
                return 1'b0;
            turbo_ticks++;
            if (west_held)
                west_ms = west_ms + 1'b1;
            if (north_held)
                north_ms = north_ms + 1'b1;
            expected_reports.push_back(build_expected_report());
            return 1'b1;
        endfunction

        function void compare_field(string name, logic [HAT_BITS-1:0] want,
                                    logic [HAT_BITS-1:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_report(report_t got);
            report_t want;
            checked++;
            if (expected_reports.size() == 0) begin
                $display("%0t: report with none expected: two=%0d one=%0d sel=%0d run=%0d hat=%0d",
                         $time, got.button_two, got.button_one, got.select_out,
                         got.run_out, got.hat);
                errors++;
                return;
            end
            want = expected_reports.pop_front();
            compare_field("button_two", {3'b000, want.button_two}, {3'b000, got.button_two});
            compare_field("button_one", {3'b000, want.button_one}, {3'b000, got.button_one});
            compare_field("select_out", {3'b000, want.select_out}, {3'b000, got.select_out});
            compare_field("run_out", {3'b000, want.run_out}, {3'b000, got.run_out});
            compare_field("hat", want.hat, got.hat);
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [PERIOD_BITS-1:0]  cfg_wdata;
    logic                    s_valid;
    logic                    s_ready;
    logic                    s_mode;
    logic [BTN_BITS-1:0]     s_pad_buttons;
    logic [STICK_BITS-1:0]   s_stick_x;
    logic [STICK_BITS-1:0]   s_stick_y;
    logic                    m_valid;
    logic                    m_ready;
    logic                    m_button_two;
    logic                    m_button_one;
    logic                    m_select_out;
    logic                    m_run_out;
    logic [HAT_BITS-1:0]     m_hat;

    gamepad_turbo_hat_mapper #(
        .ELAPSED_BITS(ELAPSED_W)
    ) u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_pad_buttons(s_pad_buttons),
        .s_stick_x    (s_stick_x),
        .s_stick_y    (s_stick_y),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_button_two (m_button_two),
        .m_button_one (m_button_one),
        .m_select_out (m_select_out),
        .m_run_out    (m_run_out),
        .m_hat        (m_hat)
    );

    turbo_report_scoreboard board;
    bit quiet_mode;         // no idling on either side while set
    bit hold_off_request;   // asks the sink for one long stall
    int reported_items;     // items that produced a report
    int cycle_count;

    // ------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------
    initial aclk = 1'b0;
    always begin
        #HALF_PERIOD_NS aclk = 1'b1;
        #HALF_PERIOD_NS aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d reports still due",
                     cycle_count, board.pending());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Idle lengths: mostly back to back, some short gaps, rare long ones
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int roll;
        if (quiet_mode)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [BTN_BITS-1:0] btn_bit(int pos);
        logic [BTN_BITS-1:0] m;
        m = '0;
        m[pos] = 1'b1;
        return m;
    endfunction

    // ------------------------------------------------------------------
    // Report sink: random stalls, plus one long hold on request so the
    // output slot fills and s_ready drops while items keep coming.
    // ------------------------------------------------------------------
    initial begin : report_sink
        int stall;
        m_ready = 1'b0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                stall = LONG_HOLD_CYCLES;
            end else begin
                stall = pick_gap();
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // every accepted report goes against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_report({m_button_two, m_button_one, m_select_out, m_run_out, m_hat});
    end

    // ------------------------------------------------------------------
    // Input channel drivers. Valid stays high from one item to the next
    // when there is no gap, so it is never dropped and raised in one step.
    // ------------------------------------------------------------------
    task automatic send_item(input logic mode, input logic [BTN_BITS-1:0] btn,
                             input logic [STICK_BITS-1:0] x,
                             input logic [STICK_BITS-1:0] y);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_mode        <= mode;
        s_pad_buttons <= btn;
        s_stick_x     <= x;
        s_stick_y     <= y;
        do
            @(posedge aclk);
        while (!s_ready);
        if (board.note_item(mode, btn, x, y))
            reported_items++;
    endtask

    task automatic send_update(input logic [BTN_BITS-1:0] btn,
                               input logic [STICK_BITS-1:0] x,
                               input logic [STICK_BITS-1:0] y);
        send_item(MODE_UPDATE, btn, x, y);
    endtask

    // tick payload is ignored by the block; random so its bits still toggle
    task automatic send_tick();
        logic [BTN_BITS-1:0]   btn;
        logic [STICK_BITS-1:0] x;
        logic [STICK_BITS-1:0] y;
        btn = BTN_BITS'($urandom);
        x   = STICK_BITS'($urandom);
        y   = STICK_BITS'($urandom);
        send_item(MODE_TICK, btn, x, y);
    endtask

    task automatic release_input();
        s_valid <= 1'b0;
    endtask

    // nothing outstanding, then room for an in-flight report to show up
    task automatic wait_idle();
        while (board.pending() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Register writes, only with the block idle
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [PERIOD_BITS-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        board.write_reg(idx, data);
    endtask

    task automatic program_regs(input logic [PERIOD_BITS-1:0] slow,
                                input logic [PERIOD_BITS-1:0] mid,
                                input logic [PERIOD_BITS-1:0] fast,
                                input logic [DZ_BITS-1:0] dz);
        write_reg(REG_PERIOD_SLOW, slow);
        write_reg(REG_PERIOD_MID, mid);
        write_reg(REG_PERIOD_FAST, fast);
        write_reg(REG_DEADZONE, {1'b0, dz});
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Random traffic. A turbo run presses west and/or north, then feeds a
    // stream of ticks with the odd update in between (shoulders, d-pad and
    // stick churn, sometimes a release). The rest is unstructured noise.
    // ------------------------------------------------------------------
    task automatic turbo_run(input int tick_span);
        logic [BTN_BITS-1:0] held;
        logic [BTN_BITS-1:0] btn;
        int                  n;
        held = '0;
        case ($urandom_range(0, 2))
            0: held = btn_bit(BTN_WEST);
            1: held = btn_bit(BTN_NORTH);
            default: held = btn_bit(BTN_WEST) | btn_bit(BTN_NORTH);
        endcase
        btn = BTN_BITS'($urandom);
        send_update(btn | held, STICK_BITS'($urandom), STICK_BITS'($urandom));
        n = $urandom_range(1, tick_span);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 85) begin
                send_tick();
            end else begin
                btn = BTN_BITS'($urandom);
                btn = btn | held;
                if ($urandom_range(0, 9) == 0)
                    btn = btn & ~held;
                send_update(btn, STICK_BITS'($urandom), STICK_BITS'($urandom));
            end
        end
    endtask

    task automatic random_phase(input int budget, input int tick_span);
        int target;
        target = reported_items + budget;
        while (reported_items < target) begin
            quiet_mode = ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 99) < 75)
                turbo_run(tick_span);
            else if ($urandom_range(0, 1) == 0)
                send_tick();
            else
                send_update(BTN_BITS'($urandom), STICK_BITS'($urandom),
                            STICK_BITS'($urandom));
        end
        quiet_mode = 1'b0;
        release_input();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        aresetn          = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = REG_PERIOD_SLOW;
        cfg_wdata        = '0;
        s_valid          = 1'b0;
        s_mode           = MODE_UPDATE;
        s_pad_buttons    = '0;
        s_stick_x        = STICK_CENTER;
        s_stick_y        = STICK_CENTER;
        quiet_mode       = 1'b0;
        hold_off_request = 1'b0;
        reported_items   = 0;
        cycle_count      = 0;
        board            = new();

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed, register defaults
        send_update('0, STICK_CENTER, STICK_CENTER);       // idle pad, hat none
        send_tick();                                       // nothing held: no report
        send_update('1, 8'd0, 8'd0);                       // everything, both shoulders
        send_update('0, 8'd255, 8'd255);                   // stick down-right
        send_update('0, 8'd0, 8'd255);                     // stick down-left
        send_update('0, 8'd192, 8'd64);                    // right on the deadzone edge
        send_update('0, 8'd193, 8'd63);                    // one step past it
        send_update(btn_bit(BTN_UP) | btn_bit(BTN_DOWN), STICK_CENTER, STICK_CENTER);
        send_update(btn_bit(BTN_LEFT) | btn_bit(BTN_RIGHT), STICK_CENTER, STICK_CENTER);
        // L1 down to slow, then again at the bottom limit
        send_update(btn_bit(BTN_L1), STICK_CENTER, STICK_CENTER);
        send_update('0, STICK_CENTER, STICK_CENTER);
        send_update(btn_bit(BTN_L1), STICK_CENTER, STICK_CENTER);
        send_update('0, STICK_CENTER, STICK_CENTER);
        // R1 up to fast, then again at the top limit
        send_update(btn_bit(BTN_R1), STICK_CENTER, STICK_CENTER);
        send_update('0, STICK_CENTER, STICK_CENTER);
        send_update(btn_bit(BTN_R1), STICK_CENTER, STICK_CENTER);
        send_update('0, STICK_CENTER, STICK_CENTER);
        send_update(btn_bit(BTN_R1), STICK_CENTER, STICK_CENTER);
        // both turbos plus home, a few ticks, then release
        send_update(btn_bit(BTN_WEST) | btn_bit(BTN_NORTH) | btn_bit(BTN_HOME),
                    STICK_CENTER, STICK_CENTER);
        repeat (4) send_tick();
        send_update('0, STICK_CENTER, STICK_CENTER);
        send_tick();

        random_phase(200, 100);
        wait_idle();

        // zero half-period acts as one; narrowest deadzone (zero)
        program_regs(8'd0, 8'd1, 8'd255, 7'd0);
        random_phase(200, 40);
        wait_idle();

        // slowest periods, largest deadzone
        program_regs(8'd255, 8'd255, 8'd255, 7'd127);
        random_phase(150, 120);
        wait_idle();

        // short periods so turbo flips often; sink holds off once early on
        program_regs(PERIOD_BITS'($urandom_range(1, 10)), PERIOD_BITS'($urandom_range(1, 10)),
                     PERIOD_BITS'($urandom_range(1, 10)), DZ_BITS'($urandom_range(0, 127)));
        hold_off_request = 1'b1;
        random_phase(250, 40);
        wait_idle();

        program_regs(PERIOD_BITS'($urandom_range(1, 20)), PERIOD_BITS'($urandom_range(1, 20)),
                     PERIOD_BITS'($urandom_range(1, 20)), DZ_BITS'($urandom_range(0, 127)));
        random_phase(250, 40);
        wait_idle();

        $display("covered %0d pad updates and %0d ticks (%0d with turbo held)",
                 board.updates, board.ticks, board.turbo_ticks);
        $display("over five register settings; %0d reports compared, %0d mismatches",
                 board.checked, board.errors);
        if (board.errors == 0 && board.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
